>>> rtl/core/assert_macros.svh
// Assertion macros included by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check an implication in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rlp_pkg.sv
// Package for the RSSI lock picker: payload types, controller states, constants
`default_nettype none
package rlp_pkg;

    localparam int FilterDepth = 8;
    localparam int HistIdxW    = 3;
    localparam int CountW      = 4;
    localparam int SumW        = 11;
    localparam int CfgIdxW     = 3;
    localparam int CfgDataW    = 16;

    localparam logic [CfgIdxW-1:0] CfgLockThreshold = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgLockHold      = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgSwitchMargin  = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgSwitchHold    = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgLost          = 3'd4;

    localparam logic signed [7:0] EmptyMean = -8'sd127;

    typedef struct packed {
        logic [47:0]       sender_address;
        logic signed [7:0] rssi_dbm;
        logic [31:0]       now_ms;
    } in_item_t;

    typedef struct packed {
        logic        locked;
        logic [47:0] candidate_address;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AGE,
        ST_CMEAN,
        ST_DECIDE,
        ST_HMEAN,
        ST_FINISH,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic age;
        logic div_start_cand;
        logic div_start_chal;
        logic decide;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic need_chal_mean;
        logic locked;
    } status_t;

endpackage
`default_nettype wire

>>> rtl/core/rlp_divider.sv
// Iterative signed divider: history sum by count, truncating toward zero
`default_nettype none
module rlp_divider (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic signed [rlp_pkg::SumW-1:0] dividend,
    input  wire logic [rlp_pkg::CountW-1:0]      divisor,
    output logic                                 done,
    output logic signed [7:0]                    quotient
);
    logic [rlp_pkg::SumW-1:0]  mag_reg, mag_next;
    logic [rlp_pkg::CountW:0]  rem_reg, rem_next;
    logic [rlp_pkg::CountW-1:0] dvs_reg, dvs_next;
    logic [3:0]                step_reg, step_next;
    logic                      neg_reg, neg_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [rlp_pkg::CountW:0]  trial;
    logic [rlp_pkg::SumW-1:0]  q_signed;

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[rlp_pkg::CountW-1:0], mag_reg[rlp_pkg::SumW-1]};
        if (start)
        begin
            neg_next  = dividend[rlp_pkg::SumW-1];
            mag_next  = dividend[rlp_pkg::SumW-1] ? -dividend : dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one quotient bit in per cycle
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                mag_next = {mag_reg[rlp_pkg::SumW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                mag_next = {mag_reg[rlp_pkg::SumW-2:0], 1'b0};
            end
            step_next = step_reg + 4'd1;
            if (step_reg == 4'(rlp_pkg::SumW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        step_reg <= step_next;
        neg_reg  <= neg_next;
    end

    assign q_signed = neg_reg ? -mag_reg : mag_reg;
    assign quotient = q_signed[7:0];
    assign done     = done_reg;
endmodule
`default_nettype wire

>>> rtl/core/rlp_datapath.sv
// Datapath: candidate and challenger tracks, config registers, decisions
`default_nettype none
module rlp_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [rlp_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [rlp_pkg::CfgDataW-1:0]  cfg_data,
    input  wire rlp_pkg::in_item_t             item,
    input  wire rlp_pkg::cmd_t                 cmd,
    output rlp_pkg::status_t                   status,
    output rlp_pkg::out_item_t                 result
);
    localparam int D = rlp_pkg::FilterDepth;
    localparam int SW = rlp_pkg::SumW;

    logic [6:0]  thr_reg, margin_reg;
    logic [15:0] lock_hold_reg, sw_hold_reg, lost_reg;

    logic                          locked_reg;
    logic [47:0]                   c_addr_reg, h_addr_reg;
    logic signed [7:0]             c_hist_reg [D];
    logic signed [7:0]             h_hist_reg [D];
    logic [rlp_pkg::CountW-1:0]    c_cnt_reg, h_cnt_reg;
    logic [31:0]                   c_seen_reg, c_hold_reg, h_seen_reg, h_hold_reg;
    rlp_pkg::in_item_t             in_reg;
    logic signed [SW-1:0]          c_sum, h_sum;
    logic signed [7:0]             c_mean_reg;
    logic                          need_h_reg;

    logic                          div_start, div_done;
    logic signed [SW-1:0]          div_num;
    logic [rlp_pkg::CountW-1:0]    div_den;
    logic signed [7:0]             div_q;

    // sums over pushed entries; histories hold zero beyond count
    always_comb
    begin
        c_sum = '0;
        h_sum = '0;
        for (int i = 0; i < D; i++)
        begin
            c_sum = c_sum + SW'(c_hist_reg[i]);
            h_sum = h_sum + SW'(h_hist_reg[i]);
        end
    end

    assign div_start = cmd.div_start_cand | cmd.div_start_chal;
    assign div_num   = cmd.div_start_cand ? c_sum : h_sum;
    assign div_den   = cmd.div_start_cand ? c_cnt_reg : h_cnt_reg;

    rlp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    logic signed [9:0] limit;
    logic signed [8:0] lock_min;
    logic              h_match;
    assign limit    = 10'(c_mean_reg) + 10'($signed({1'b0, margin_reg}));
    assign lock_min = -$signed({2'b0, thr_reg});
    assign h_match  = (h_cnt_reg != '0) && (h_addr_reg == in_reg.sender_address);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= 7'd50;
            lock_hold_reg <= 16'd2000;
            margin_reg    <= 7'd3;
            sw_hold_reg   <= 16'd500;
            lost_reg      <= 16'd1000;
            locked_reg    <= 1'b0;
            c_addr_reg    <= '0;
            h_addr_reg    <= '0;
            c_cnt_reg     <= '0;
            h_cnt_reg     <= '0;
            c_seen_reg    <= '0;
            c_hold_reg    <= '0;
            h_seen_reg    <= '0;
            h_hold_reg    <= '0;
            need_h_reg    <= 1'b0;
            c_mean_reg    <= '0;
            for (int i = 0; i < D; i++)
            begin
                c_hist_reg[i] <= '0;
                h_hist_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rlp_pkg::CfgLockThreshold: thr_reg       <= cfg_data[6:0];
                    rlp_pkg::CfgLockHold:      lock_hold_reg <= cfg_data;
                    rlp_pkg::CfgSwitchMargin:  margin_reg    <= cfg_data[6:0];
                    rlp_pkg::CfgSwitchHold:    sw_hold_reg   <= cfg_data;
                    rlp_pkg::CfgLost:          lost_reg      <= cfg_data;
                    default: ;
                endcase
            end
            // drop stale tracks
            if (cmd.age)
            begin
                if (c_cnt_reg != '0 && (in_reg.now_ms - c_seen_reg) > {16'd0, lost_reg})
                begin
                    c_addr_reg <= '0;
                    c_cnt_reg  <= '0;
                    c_seen_reg <= '0;
                    c_hold_reg <= '0;
                    for (int i = 0; i < D; i++) c_hist_reg[i] <= '0;
                end
                if (h_cnt_reg != '0 && (in_reg.now_ms - h_seen_reg) > {16'd0, sw_hold_reg})
                begin
                    h_addr_reg <= '0;
                    h_cnt_reg  <= '0;
                    h_seen_reg <= '0;
                    h_hold_reg <= '0;
                    for (int i = 0; i < D; i++) h_hist_reg[i] <= '0;
                end
            end
            if (cmd.div_start_cand)
                need_h_reg <= 1'b0;
            if (div_done && !need_h_reg)
                c_mean_reg <= (c_cnt_reg == '0) ? rlp_pkg::EmptyMean : div_q;
            // candidate push, or challenger start/push
            if (cmd.decide)
            begin
                if (c_cnt_reg == '0 || c_addr_reg == in_reg.sender_address)
                begin
                    if (c_cnt_reg == '0)
                    begin
                        c_addr_reg <= in_reg.sender_address;
                        c_hold_reg <= in_reg.now_ms;
                    end
                    if (c_cnt_reg < rlp_pkg::CountW'(D))
                        c_cnt_reg <= c_cnt_reg + 1'b1;
                    for (int i = D - 1; i > 0; i--) c_hist_reg[i] <= c_hist_reg[i-1];
                    c_hist_reg[0] <= in_reg.rssi_dbm;
                    c_seen_reg <= in_reg.now_ms;
                    need_h_reg <= 1'b0;
                end
                else if (!h_match)
                begin
                    if (10'(in_reg.rssi_dbm) > limit)
                    begin
                        h_addr_reg <= in_reg.sender_address;
                        h_cnt_reg  <= rlp_pkg::CountW'(1);
                        h_hist_reg[0] <= in_reg.rssi_dbm;
                        for (int i = 1; i < D; i++) h_hist_reg[i] <= '0;
                        h_seen_reg <= in_reg.now_ms;
                        h_hold_reg <= in_reg.now_ms;
                    end
                end
                else
                begin
                    if (h_cnt_reg < rlp_pkg::CountW'(D))
                        h_cnt_reg <= h_cnt_reg + 1'b1;
                    for (int i = D - 1; i > 0; i--) h_hist_reg[i] <= h_hist_reg[i-1];
                    h_hist_reg[0] <= in_reg.rssi_dbm;
                    h_seen_reg <= in_reg.now_ms;
                    need_h_reg <= 1'b1;
                end
            end
            // commit: lock check for candidate path, switch check for challenger
            if (cmd.finish)
            begin
                if (!need_h_reg)
                begin
                    if (c_addr_reg == in_reg.sender_address)
                    begin
                        if (div_q >= 8'(lock_min))
                        begin
                            if ((in_reg.now_ms - c_hold_reg) >= {16'd0, lock_hold_reg})
                                locked_reg <= 1'b1;
                        end
                        else
                            c_hold_reg <= in_reg.now_ms;
                    end
                end
                else if (10'(div_q) <= limit)
                begin
                    h_addr_reg <= '0;
                    h_cnt_reg  <= '0;
                    h_seen_reg <= '0;
                    h_hold_reg <= '0;
                    for (int i = 0; i < D; i++) h_hist_reg[i] <= '0;
                end
                else if ((in_reg.now_ms - h_hold_reg) >= {16'd0, sw_hold_reg})
                begin
                    c_addr_reg <= h_addr_reg;
                    c_cnt_reg  <= h_cnt_reg;
                    c_seen_reg <= h_seen_reg;
                    c_hold_reg <= in_reg.now_ms;
                    for (int i = 0; i < D; i++) c_hist_reg[i] <= h_hist_reg[i];
                    h_addr_reg <= '0;
                    h_cnt_reg  <= '0;
                    h_seen_reg <= '0;
                    h_hold_reg <= '0;
                    for (int i = 0; i < D; i++) h_hist_reg[i] <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= item;
    end

    assign status.div_done       = div_done;
    assign status.need_chal_mean = need_h_reg;
    assign status.locked         = locked_reg;
    assign result.locked            = locked_reg;
    assign result.candidate_address = c_addr_reg;
endmodule
`default_nettype wire

>>> rtl/core/rlp_ctrl.sv
// Controller: sequences one transaction through aging, means and decisions, or straight to output once locked
`default_nettype none
module rlp_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire rlp_pkg::status_t status,
    output rlp_pkg::cmd_t         cmd
);
    rlp_pkg::state_t state_reg, state_next;
    logic            entry_reg, entry_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rlp_pkg::ST_IDLE:
                if (in_valid) state_next = status.locked ? rlp_pkg::ST_OUT : rlp_pkg::ST_AGE;
            rlp_pkg::ST_AGE:    state_next = rlp_pkg::ST_CMEAN;
            rlp_pkg::ST_CMEAN:  if (status.div_done) state_next = rlp_pkg::ST_DECIDE;
            rlp_pkg::ST_DECIDE: state_next = rlp_pkg::ST_HMEAN;
            rlp_pkg::ST_HMEAN:  if (status.div_done) state_next = rlp_pkg::ST_FINISH;
            rlp_pkg::ST_FINISH: state_next = rlp_pkg::ST_OUT;
            rlp_pkg::ST_OUT:    if (out_ready) state_next = rlp_pkg::ST_IDLE;
            default:            state_next = rlp_pkg::ST_IDLE;
        endcase
    end

    // high on the first cycle spent in a state
    assign entry_next = (state_next != state_reg);

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            rlp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            rlp_pkg::ST_AGE:    cmd.age = 1'b1;
            rlp_pkg::ST_CMEAN:  cmd.div_start_cand = entry_reg;
            rlp_pkg::ST_DECIDE: cmd.decide = 1'b1;
            rlp_pkg::ST_HMEAN:
            begin
                // candidate path re-divides the candidate, challenger path the challenger
                cmd.div_start_cand = entry_reg && !status.need_chal_mean;
                cmd.div_start_chal = entry_reg && status.need_chal_mean;
            end
            rlp_pkg::ST_FINISH: cmd.finish = 1'b1;
            rlp_pkg::ST_OUT:    out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlp_pkg::ST_IDLE;
            entry_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/rssi_lock_picker.sv
// Sequence from input accept to output valid: age, two mean steps on the shared
// 11-step divider, decide, finish; straight to output once locked.
// A new transaction is accepted only after the previous result is taken.
// Reset: rst_n asynchronous active low; clears tracks, lock flag, and
// loads register defaults.
`default_nettype none
`include "assert_macros.svh"
module rssi_lock_picker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire rlp_pkg::in_item_t            in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output rlp_pkg::out_item_t                out_data,
    input  wire logic                         cfg_we,
    input  wire logic [rlp_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [rlp_pkg::CfgDataW-1:0] cfg_data
);
    rlp_pkg::cmd_t    cmd;
    rlp_pkg::status_t status;

    rlp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rlp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (in_data),
        .cmd       (cmd),
        .status    (status),
        .result    (out_data)
    );

    `ASSERT_IMPL(a_no_overlap, in_ready, !out_valid, "input and output open together")
    `ASSERT_NEXT(a_lock_sticky, out_data.locked, out_data.locked, "lock flag dropped")
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn")
endmodule
`default_nettype wire
